/* sv/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the two-level page table walker: memory
// geometry, queue depths, the classified item, the result and the memory
// request.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int BYTE_W      = 8;
  localparam int WORD_BYTES  = 4;
  localparam int WORD_W      = BYTE_W * WORD_BYTES;
  localparam int NUM_BANKS   = WORD_BYTES;
  localparam int LANE_W      = $clog2(NUM_BANKS);
  localparam int ROWS        = MEM_BYTES / NUM_BANKS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int VA_W        = 14;
  localparam int IDX_W       = 4;
  localparam int OFFSET_W    = 6;
  localparam int FRAME_W     = ADDR_W - OFFSET_W;
  localparam int FRONT_DEPTH = 4;
  localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
  localparam int FRONT_CNT_W = $clog2(FRONT_DEPTH + 1);
  localparam int RES_DEPTH   = 2;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XLATE = 1'b1
  } ptw_op_t;

  typedef struct packed {
    ptw_op_t                 op;
    logic [ADDR_W-1:0]       byte_addr;
    logic [BYTE_W-1:0]       byte_value;
    logic [VA_W-1:0]         virtual_addr;
  } ptw_item_t;

  typedef struct packed {
    logic                    outer_valid;
    logic                    inner_valid;
    logic [ADDR_W-1:0]       phys_addr;
    logic [WORD_W-1:0]       word_data;
  } ptw_result_t;

  typedef struct packed {
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [BYTE_W-1:0]       wr_data;
  } ptw_mem_req_t;

endpackage

/* sv/ptw_front.sv */
// ----------------------------------------------------------------------------
// ptw_front
// Front end: accepts input transactions, classifies them as byte writes or
// translations and holds them in a short queue for the walker.
// ----------------------------------------------------------------------------
module ptw_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      command,
  input  logic [ptw_pkg::ADDR_W-1:0] byte_addr,
  input  logic [ptw_pkg::BYTE_W-1:0] byte_value,
  input  logic [ptw_pkg::VA_W-1:0]  virtual_addr,
  output logic                      full,
  output logic                      head_valid,
  output ptw_pkg::ptw_item_t        head,
  input  logic                      pop
);
  import ptw_pkg::*;

  ptw_item_t              queue_r [FRONT_DEPTH];
  logic [FRONT_PTR_W-1:0] wr_ptr_r;
  logic [FRONT_PTR_W-1:0] rd_ptr_r;
  logic [FRONT_CNT_W-1:0] cnt_r;
  ptw_item_t              item;
  logic                   do_push;
  logic                   do_pop;

  always_comb begin
    item.op           = command ? OP_XLATE : OP_WRITE;
    item.byte_addr    = byte_addr;
    item.byte_value   = byte_value;
    item.virtual_addr = virtual_addr;
  end

  assign full       = (cnt_r == FRONT_CNT_W'(FRONT_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = queue_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* sv/ptw_mem.sv */
// ----------------------------------------------------------------------------
// ptw_mem
// Physical memory as four byte banks, so that one word at any byte address
// is read in one access. Clears itself after reset, one row per cycle.
// ----------------------------------------------------------------------------
module ptw_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptw_pkg::ptw_mem_req_t       req,
  output logic [ptw_pkg::WORD_W-1:0]  rd_word,
  output logic                        clearing
);
  import ptw_pkg::*;

  logic                              clr_busy_r;
  logic [ROW_W-1:0]                  clr_cnt_r;
  logic [LANE_W-1:0]                 off_r;
  logic [NUM_BANKS-1:0]              past_r;
  logic [NUM_BANKS-1:0][BYTE_W-1:0]  rdata_r;
  logic [ROW_W-1:0]                  row_base;
  logic [LANE_W-1:0]                 rd_off;

  assign clearing = clr_busy_r;
  assign row_base = req.rd_addr[ADDR_W-1:LANE_W];
  assign rd_off   = req.rd_addr[LANE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r <= rd_off;
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [BYTE_W-1:0] bank_mem [ROWS];
    logic              wrap;
    logic [ROW_W-1:0]  rd_row;
    logic              we;
    logic [ROW_W-1:0]  wr_row;
    logic [BYTE_W-1:0] wr_byte;

    assign wrap    = (LANE_W'(b) < rd_off);
    assign rd_row  = row_base + ROW_W'(wrap);
    assign we      = clr_busy_r ||
                     (req.wr_en && (req.wr_addr[LANE_W-1:0] == LANE_W'(b)));
    assign wr_row  = clr_busy_r ? clr_cnt_r : req.wr_addr[ADDR_W-1:LANE_W];
    assign wr_byte = clr_busy_r ? '0 : req.wr_data;

    always_ff @(posedge clk) begin
      if (we) begin
        bank_mem[wr_row] <= wr_byte;
      end
      rdata_r[b] <= bank_mem[rd_row];
      past_r[b]  <= wrap && (row_base == ROW_W'(ROWS - 1));
    end
  end

  // byte zero of the word sits in the top bits
  always_comb begin
    logic [LANE_W-1:0] lane;
    lane = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      lane = off_r + LANE_W'(k);
      rd_word[WORD_W-1-BYTE_W*k -: BYTE_W] = past_r[lane] ? '0 : rdata_r[lane];
    end
  end

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(req.rd_en || req.wr_en))
    else $error("memory access during clearing pass");

  a_clear_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing pass restarted without reset");

endmodule

/* sv/ptw_walker.sv */
// ----------------------------------------------------------------------------
// ptw_walker
// Back end: carries out queued transactions. Byte writes go straight to
// memory; translations walk outer entry, inner entry and data word, and
// the result lands in a two-entry result queue.
// ----------------------------------------------------------------------------
module ptw_walker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ptw_pkg::ADDR_W-1:0]  table_base,
  input  logic                        head_valid,
  input  ptw_pkg::ptw_item_t          head,
  output logic                        pop,
  output ptw_pkg::ptw_mem_req_t       mem_req,
  input  logic [ptw_pkg::WORD_W-1:0]  rd_word,
  input  logic                        res_pop,
  output logic                        res_empty,
  output ptw_pkg::ptw_result_t        res_head
);
  import ptw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OUTER,
    ST_INNER,
    ST_DATA
  } state_t;

  state_t               st_r, st_nxt;
  logic [VA_W-1:0]      va_r, va_nxt;
  logic [ADDR_W-1:0]    pa_r, pa_nxt;
  ptw_result_t          res_q_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_r;
  logic [RES_PTR_W-1:0] res_rd_r;
  logic [RES_CNT_W-1:0] res_cnt_r;
  logic                 res_push;
  ptw_result_t          res_in;
  logic                 res_room;
  logic                 do_res_pop;
  logic [ADDR_W-1:0]    outer_addr;
  logic [ADDR_W-1:0]    inner_addr;

  assign res_room   = (res_cnt_r < RES_CNT_W'(RES_DEPTH));
  assign res_empty  = (res_cnt_r == '0);
  assign res_head   = res_q_r[res_rd_r];
  assign do_res_pop = res_pop && !res_empty;

  // word-sized entries, index scaled by four
  assign outer_addr = table_base +
      ADDR_W'({head.virtual_addr[VA_W-1 -: IDX_W], {LANE_W{1'b0}}});
  assign inner_addr = rd_word[WORD_W-1 -: ADDR_W] +
      ADDR_W'({va_r[OFFSET_W+IDX_W-1 -: IDX_W], {LANE_W{1'b0}}});

  always_comb begin
    st_nxt   = st_r;
    va_nxt   = va_r;
    pa_nxt   = pa_r;
    pop      = 1'b0;
    mem_req  = '0;
    res_push = 1'b0;
    res_in   = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (head_valid) begin
          if (head.op == OP_WRITE) begin
            pop             = 1'b1;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = head.byte_addr;
            mem_req.wr_data = head.byte_value;
          end else if (res_room) begin
            pop             = 1'b1;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = outer_addr;
            va_nxt          = head.virtual_addr;
            st_nxt          = ST_OUTER;
          end
        end
      end
      ST_OUTER: begin
        if (rd_word[0]) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = inner_addr;
          st_nxt          = ST_INNER;
        end else begin
          res_push = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      ST_INNER: begin
        if (rd_word[0]) begin
          pa_nxt          = {rd_word[WORD_W-1 -: FRAME_W], va_r[OFFSET_W-1:0]};
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = pa_nxt;
          st_nxt          = ST_DATA;
        end else begin
          res_push           = 1'b1;
          res_in.outer_valid = 1'b1;
          st_nxt             = ST_IDLE;
        end
      end
      ST_DATA: begin
        res_push           = 1'b1;
        res_in.outer_valid = 1'b1;
        res_in.inner_valid = 1'b1;
        res_in.phys_addr   = pa_r;
        res_in.word_data   = rd_word;
        st_nxt             = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    va_r <= va_nxt;
    pa_r <= pa_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) begin
        res_wr_r <= res_wr_r + 1'b1;
      end
      if (do_res_pop) begin
        res_rd_r <= res_rd_r + 1'b1;
      end
      case ({res_push, do_res_pop})
        2'b10:   res_cnt_r <= res_cnt_r + 1'b1;
        2'b01:   res_cnt_r <= res_cnt_r - 1'b1;
        default: res_cnt_r <= res_cnt_r;
      endcase
    end
  end

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_cnt_r < RES_CNT_W'(RES_DEPTH)))
    else $error("result queue overflow");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == ST_IDLE) && head_valid)
    else $error("front queue popped outside idle");

  a_data_after_inner: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DATA) |-> ($past(st_r) == ST_INNER))
    else $error("data read without inner entry");

endmodule

/* sv/two_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// Byte-writable 4 KiB physical memory with a two-level page table walker.
// ----------------------------------------------------------------------------
// After reset the memory clears itself, one row of four bank bytes per
// cycle; in_full stays high during that pass, while configuration writes
// are taken at any time. Transactions enter a four-deep queue and run one
// at a time: a byte write goes straight to memory, and a translation ends
// after the outer entry read when that entry is invalid, after the inner
// entry read when that one is invalid, and otherwise after the data word
// read; the three word reads are dependent, and the banked memory read port
// returns each word registered. Results leave through a two-entry queue.
module two_level_page_table_walker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_command,
  input  logic [ptw_pkg::ADDR_W-1:0]  in_byte_addr,
  input  logic [ptw_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic [ptw_pkg::VA_W-1:0]    in_virtual_addr,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_outer_valid,
  output logic                        out_inner_valid,
  output logic [ptw_pkg::ADDR_W-1:0]  out_phys_addr,
  output logic [ptw_pkg::WORD_W-1:0]  out_word_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptw_pkg::ADDR_W-1:0]  cfg_table_base
);
  import ptw_pkg::*;

  logic [ADDR_W-1:0] table_base_r;
  logic              front_full;
  logic              head_valid;
  ptw_item_t         head;
  logic              pop;
  ptw_mem_req_t      mem_req;
  logic [WORD_W-1:0] rd_word;
  logic              clearing;
  ptw_result_t       res_head;

  assign cfg_ready = 1'b1;
  assign in_full   = front_full || clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_base_r <= cfg_table_base;
    end
  end

  ptw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push && !in_full),
    .command      (in_command),
    .byte_addr    (in_byte_addr),
    .byte_value   (in_byte_value),
    .virtual_addr (in_virtual_addr),
    .full         (front_full),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop)
  );

  ptw_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_word  (rd_word),
    .clearing (clearing)
  );

  ptw_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_base (table_base_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .mem_req    (mem_req),
    .rd_word    (rd_word),
    .res_pop    (out_pop),
    .res_empty  (out_empty),
    .res_head   (res_head)
  );

  assign out_outer_valid = res_head.outer_valid;
  assign out_inner_valid = res_head.inner_valid;
  assign out_phys_addr   = res_head.phys_addr;
  assign out_word_data   = res_head.word_data;

endmodule
